// File: sv/fqva_pkg.sv
// shared types, constants and the arctangent table for the flow q-vector accumulator
package fqva_pkg;

  localparam int unsigned ATAN_DEPTH = 24;
  localparam int unsigned ATAN_IDX_W = 5;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned WT_W       = 32;
  localparam int unsigned TRIG_W     = 17;
  localparam int unsigned PROD_W     = 33;
  localparam int unsigned Q_W        = 16;
  localparam int unsigned MULT_W     = 15;
  localparam int unsigned HARM_W     = 4;
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned WEIGHT_W   = 16;

  localparam logic [HARM_W-1:0] HARMONIC_RESET = 4'd2;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_ADD_END = 2'd1;
  localparam logic [1:0] CMD_END     = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic [PHASE_W-1:0]         phase_angle;
    logic signed [WEIGHT_W-1:0] track_weight;
  } fqva_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] q_x;
    logic signed [Q_W-1:0] q_y;
    logic [MULT_W-1:0]     multiplicity;
    logic                  empty_event;
    logic                  zero_weight;
  } fqva_out_t;

  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: sv/fqva_cordic.sv
// iterative cordic rotation giving cos and sin of a binary angle in q2.15
module fqva_cordic #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [fqva_pkg::PHASE_W-1:0]         angle,
  output logic                                 done,
  output logic signed [fqva_pkg::TRIG_W-1:0]   cos_val,
  output logic signed [fqva_pkg::TRIG_W-1:0]   sin_val
);
  import fqva_pkg::*;

  localparam logic [31:0] KEEP_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(CORDIC_STEPS - 1);
  localparam logic signed [33:0] X_INIT = 34'sd652032874;

  typedef enum logic [1:0] {ST_IDLE, ST_ROT, ST_FIN} state_t;

  state_t                  state_r, state_nxt;
  logic signed [33:0]      x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0]      z_r, z_nxt;
  logic [1:0]              quad_r, quad_nxt;
  logic [ATAN_IDX_W-1:0]   step_r, step_nxt;
  logic                    done_r, done_nxt;
  logic signed [TRIG_W-1:0] cos_r, cos_nxt, sin_r, sin_nxt;
  logic [31:0]             ang;
  logic signed [33:0]      dx, dy, cx, cy;
  logic signed [31:0]      atan_s;

  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [34:0] r;
    t = $signed({v[33], v}) + 35'sd16384;
    r = t >>> 15;
    if (r > 35'sd32768) begin
      r = 35'sd32768;
    end else if (r < -35'sd32768) begin
      r = -35'sd32768;
    end
    return TRIG_W'(r);
  endfunction

  assign ang    = {angle, 16'h0000} & KEEP_MASK;
  assign dx     = y_r >>> step_r;
  assign dy     = x_r >>> step_r;
  assign atan_s = $signed(atan_turn(step_r));

  always_comb begin
    case (quad_r)
      2'd1: begin
        cx = -y_r;
        cy = x_r;
      end
      2'd2: begin
        cx = -x_r;
        cy = -y_r;
      end
      2'd3: begin
        cx = y_r;
        cy = -x_r;
      end
      default: begin
        cx = x_r;
        cy = y_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    quad_nxt  = quad_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    cos_nxt   = cos_r;
    sin_nxt   = sin_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_nxt     = X_INIT;
          y_nxt     = '0;
          z_nxt     = $signed({2'b00, ang[29:0]});
          quad_nxt  = ang[31:30];
          step_nxt  = '0;
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        if (!z_r[31]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_s;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_s;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cos_nxt   = to_q15(cx);
        sin_nxt   = to_q15(cy);
        done_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    quad_r <= quad_nxt;
    step_r <= step_nxt;
    cos_r  <= cos_nxt;
    sin_r  <= sin_nxt;
  end

  assign done    = done_r;
  assign cos_val = cos_r;
  assign sin_val = sin_r;

endmodule

// File: sv/fqva_divider.sv
// restoring divider giving a rounded, saturated q1.15 quotient of a sum by a weight
module fqva_divider (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [fqva_pkg::SUM_W-1:0]  sum,
  input  logic [fqva_pkg::WT_W-1:0]          den,
  output logic                               done,
  output logic signed [fqva_pkg::Q_W-1:0]    quot
);
  import fqva_pkg::*;

  localparam int unsigned BIT_W = $clog2(Q_W);
  localparam int unsigned REM_W = SUM_W + 1;
  localparam logic [Q_W-1:0] POS_MAX = 16'h7FFF;
  localparam logic [Q_W-1:0] NEG_MAX = 16'h8000;

  typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_CHK, ST_ITER, ST_FIN} state_t;

  state_t               state_r, state_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [WT_W-1:0]      den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]     dsh_r, dsh_nxt;
  logic [Q_W-1:0]       quo_r, quo_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic                 done_r, done_nxt;
  logic signed [Q_W-1:0] q_r, q_nxt;
  logic [SUM_W-1:0]     mag;
  logic                 fits;

  assign mag  = neg_r ? (~sum_r + 1'b1) : sum_r;
  assign fits = rem_r >= {1'b0, dsh_r};

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    quo_nxt   = quo_r;
    bit_nxt   = bit_r;
    done_nxt  = 1'b0;
    q_nxt     = q_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          sum_nxt   = sum;
          den_nxt   = den;
          neg_nxt   = sum[SUM_W-1];
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rem_nxt   = {1'b0, mag} + REM_W'(den_r >> 1);
        dsh_nxt   = {den_r, 16'h0000};
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        ovf_nxt   = fits;
        dsh_nxt   = dsh_r >> 1;
        bit_nxt   = BIT_W'(Q_W - 1);
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        if (fits) begin
          rem_nxt = rem_r - {1'b0, dsh_r};
        end
        quo_nxt = {quo_r[Q_W-2:0], fits};
        dsh_nxt = dsh_r >> 1;
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (neg_r) begin
          q_nxt = (ovf_r || quo_r > NEG_MAX) ? $signed(NEG_MAX) : $signed(~quo_r + 1'b1);
        end else begin
          q_nxt = (ovf_r || quo_r > POS_MAX) ? $signed(POS_MAX) : $signed(quo_r);
        end
        done_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    sum_r <= sum_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
    bit_r <= bit_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: sv/flow_q_vector_accumulator_core.sv
// top level of the flow q-vector accumulator: sequencer, event sums and result register
//
// requests arrive on in_req and are taken at a clock edge where start is high and busy
// is low; busy stays high while a request is worked on, so requests are taken one by one.
// an add request, if the track count is below MAX_TRACKS_PER_EVENT, scales the track
// angle by the harmonic order, rotates it through the cordic unit, multiplies by the
// weight and adds to the event sums. an end request divides both sums by the absolute
// weight sum with one shared restoring divider, one quotient after the other, and the
// result goes out after both quotients; an empty event or a zero weight sum skips
// division and is flagged instead. results appear on out_rsp for exactly one cycle
// with out_valid high; the receiver cannot stall, so each result must be taken then.
// an end request gives one result and clears the event; an unused command is dropped.
// cfg_we writes the harmonic order from cfg_wdata, to be done only while busy is low.
// synchronous reset clears the event sums, the track count and the sequencer and sets
// the harmonic order to 2.
module flow_q_vector_accumulator_core #(
  parameter int MAX_TRACKS_PER_EVENT = 16384,
  parameter int ANGLE_BITS           = 16,
  parameter int CORDIC_STEPS         = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  fqva_pkg::fqva_in_t              in_req,
  output logic                            busy,
  output logic                            out_valid,
  output fqva_pkg::fqva_out_t             out_rsp,
  input  logic                            cfg_we,
  input  logic [fqva_pkg::HARM_W-1:0]     cfg_wdata
);
  import fqva_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TRACKS_PER_EVENT + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRACKS_PER_EVENT);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DEC, ST_ROT, ST_ACC, ST_CHK, ST_DIVX, ST_DIVY, ST_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [1:0]                 cmd_r, cmd_nxt;
  logic [PHASE_W-1:0]         nphase_r, nphase_nxt;
  logic signed [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic [HARM_W-1:0]          harmonic_r, harmonic_nxt;
  logic signed [SUM_W-1:0]    cos_sum_r, cos_sum_nxt, sin_sum_r, sin_sum_nxt;
  logic signed [WT_W-1:0]     wt_r, wt_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0]   prod_c_r, prod_c_nxt, prod_s_r, prod_s_nxt;
  logic signed [Q_W-1:0]      qx_r, qx_nxt, qy_r, qy_nxt;
  logic                       empty_r, empty_nxt, zerow_r, zerow_nxt;
  logic                       out_valid_r, out_valid_nxt;
  fqva_out_t                  out_rsp_r, out_rsp_nxt;

  logic                       accept;
  logic                       add_ok;
  logic                       is_end;
  logic                       cordic_start, cordic_done;
  logic signed [TRIG_W-1:0]   cos_val, sin_val;
  logic                       div_start, div_done;
  logic signed [SUM_W-1:0]    div_sum;
  logic [WT_W-1:0]            div_den;
  logic signed [Q_W-1:0]      div_q;

  assign accept = start && (state_r == ST_IDLE);
  assign add_ok = (cmd_r == CMD_ADD || cmd_r == CMD_ADD_END) && (cnt_r < CNT_MAX);
  assign is_end = (cmd_r == CMD_ADD_END || cmd_r == CMD_END);

  assign cordic_start = (state_r == ST_DEC) && (cmd_r != CMD_NOP) && add_ok;
  assign div_start    = ((state_r == ST_CHK) && (cnt_r != '0) && (wt_r != '0)) ||
                        ((state_r == ST_DIVX) && div_done);
  assign div_sum      = (state_r == ST_CHK) ? cos_sum_r : sin_sum_r;
  assign div_den      = wt_r[WT_W-1] ? (~wt_r + 1'b1) : wt_r;

  fqva_cordic #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .angle   (nphase_r),
    .done    (cordic_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  fqva_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum   (div_sum),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    nphase_nxt    = nphase_r;
    weight_nxt    = weight_r;
    harmonic_nxt  = cfg_we ? cfg_wdata : harmonic_r;
    cos_sum_nxt   = cos_sum_r;
    sin_sum_nxt   = sin_sum_r;
    wt_nxt        = wt_r;
    cnt_nxt       = cnt_r;
    prod_c_nxt    = prod_c_r;
    prod_s_nxt    = prod_s_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    empty_nxt     = empty_r;
    zerow_nxt     = zerow_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_req.cmd;
          nphase_nxt = PHASE_W'(harmonic_r * in_req.phase_angle);
          weight_nxt = in_req.track_weight;
          state_nxt  = ST_DEC;
        end
      end
      ST_DEC: begin
        if (cmd_r == CMD_NOP) begin
          state_nxt = ST_IDLE;
        end else if (add_ok) begin
          state_nxt = ST_ROT;
        end else if (is_end) begin
          state_nxt = ST_CHK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ROT: begin
        if (cordic_done) begin
          prod_c_nxt = PROD_W'(weight_r) * PROD_W'(cos_val);
          prod_s_nxt = PROD_W'(weight_r) * PROD_W'(sin_val);
          state_nxt  = ST_ACC;
        end
      end
      ST_ACC: begin
        cos_sum_nxt = cos_sum_r + SUM_W'(prod_c_r);
        sin_sum_nxt = sin_sum_r + SUM_W'(prod_s_r);
        wt_nxt      = wt_r + WT_W'(weight_r);
        cnt_nxt     = cnt_r + 1'b1;
        state_nxt   = is_end ? ST_CHK : ST_IDLE;
      end
      ST_CHK: begin
        qx_nxt    = '0;
        qy_nxt    = '0;
        empty_nxt = 1'b0;
        zerow_nxt = 1'b0;
        if (cnt_r == '0) begin
          empty_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end else if (wt_r == '0) begin
          zerow_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (div_done) begin
          qx_nxt    = div_q;
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          qy_nxt    = div_q;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_rsp_nxt.q_x          = qx_r;
        out_rsp_nxt.q_y          = qy_r;
        out_rsp_nxt.multiplicity = MULT_W'(cnt_r);
        out_rsp_nxt.empty_event  = empty_r;
        out_rsp_nxt.zero_weight  = zerow_r;
        out_valid_nxt            = 1'b1;
        cos_sum_nxt              = '0;
        sin_sum_nxt              = '0;
        wt_nxt                   = '0;
        cnt_nxt                  = '0;
        state_nxt                = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      harmonic_r  <= HARMONIC_RESET;
      cos_sum_r   <= '0;
      sin_sum_r   <= '0;
      wt_r        <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      harmonic_r  <= harmonic_nxt;
      cos_sum_r   <= cos_sum_nxt;
      sin_sum_r   <= sin_sum_nxt;
      wt_r        <= wt_nxt;
      cnt_r       <= cnt_nxt;
    end
    cmd_r     <= cmd_nxt;
    nphase_r  <= nphase_nxt;
    weight_r  <= weight_nxt;
    prod_c_r  <= prod_c_nxt;
    prod_s_r  <= prod_s_nxt;
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    empty_r   <= empty_nxt;
    zerow_r   <= zerow_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// File: sv/fqva_checker.sv
// port-level checker for the flow q-vector accumulator, bound to the top level
module fqva_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input fqva_pkg::fqva_out_t         out_rsp
);
  import fqva_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_rsp.empty_event && out_rsp.zero_weight))
    else $error("empty and zero weight flags both set");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.empty_event |->
      out_rsp.multiplicity == '0 && out_rsp.q_x == '0 && out_rsp.q_y == '0)
    else $error("empty event result not all zero");

  a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.zero_weight |-> out_rsp.q_x == '0 && out_rsp.q_y == '0)
    else $error("zero weight result has nonzero components");

endmodule

bind flow_q_vector_accumulator_core fqva_checker u_fqva_checker (.*);
